### src/lcof_pkg.sv
// Shared widths, register indexes, reset values and helpers for the
// limit-cycle obstacle field datapath. No dependencies.
package lcof_pkg;

  localparam int FRAC_BITS_DEF = 8;

  // Field widths of the stream beats and the configuration registers.
  localparam int POS_W   = 16;
  localparam int OBS_W   = 13;
  localparam int RAD_W   = 12;
  localparam int ROT_W   = 16;
  localparam int CONV_W  = 13;
  localparam int SCALE_W = 16;
  localparam int LIM_W   = 15;
  localparam int FORCE_W = 16;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Internal datapath widths.
  localparam int DIFF_W = POS_W + 1;          // vehicle minus obstacle
  localparam int SQ_W   = 2 * DIFF_W;         // signed square product
  localparam int DSQ_W  = 33;                 // dx^2 + dy^2, unsigned
  localparam int R2_W   = 2 * RAD_W;          // radius squared
  localparam int ROTP_W = DIFF_W + ROT_W;     // alpha * d
  localparam int GD_W   = CONV_W + RAD_W + 1; // gamma * d, d within radius
  localparam int GC_W   = GD_W + R2_W + 1;    // gamma * d * c
  localparam int SUM_W  = GC_W + 1;
  localparam int SAT_W  = 32;
  localparam int SPROD_W = SAT_W + SCALE_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RADIUS    = 3'd0,
    REG_ROT_GAIN  = 3'd1,
    REG_CONV_GAIN = 3'd2,
    REG_SCALE_X   = 3'd3,
    REG_SCALE_Y   = 3'd4,
    REG_LIMIT_X   = 3'd5,
    REG_LIMIT_Y   = 3'd6
  } cfg_reg_t;

  localparam logic [RAD_W-1:0]   RADIUS_RST    = 12'd0;
  localparam logic [ROT_W-1:0]   ROT_GAIN_RST  = 16'd256;
  localparam logic [CONV_W-1:0]  CONV_GAIN_RST = 13'd0;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 16'd256;
  localparam logic [LIM_W-1:0]   LIMIT_RST     = 15'd25600;

  // Saturate a wide signed sum to a signed 32-bit value.
  function automatic logic signed [SAT_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}};
    lo = {{(SUM_W-SAT_W+1){1'b1}}, {(SAT_W-1){1'b0}}};
    if (v > hi) begin
      sat32 = hi[SAT_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[SAT_W-1:0];
    end else begin
      sat32 = v[SAT_W-1:0];
    end
  endfunction

endpackage

### src/limit_cycle_obstacle_field.sv
// Limit-cycle obstacle avoidance field: seven-stage pipelined datapath with
// its configuration registers. Depends on lcof_pkg.
//
// Usage: each input beat carries the vehicle position (signed Q8.8) and an
// obstacle center (signed Q5.8). The block returns one output beat per input
// beat with the scaled and clamped field components and an active flag that
// is set when the vehicle lies within the cycle radius; outside it both
// components are 0. The user must write the registers only while the
// pipeline holds no beats, through cfg_we/cfg_addr/cfg_wdata; the block
// does not enforce this. Writes to indexes beyond the register list are
// dropped. A beat passes through seven register stages (difference,
// products, distance test, convergence product, sum and saturate, scale
// product, clamp into the output register). While the output accepts beats,
// throughput is one beat per cycle. Each stage carries its own valid bit and
// loads whenever it is empty or the stage after it moves, so bubbles close up
// and the input keeps accepting while a stalled result waits at the output,
// until all seven stages are full. Reset empties the pipeline and returns the
// registers to their defaults.
module limit_cycle_obstacle_field
  import lcof_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] vehicle_x, [31:16] vehicle_y, [44:32] obstacle_x,
  // [57:45] obstacle_y, [63:58] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] force_x, [31:16] force_y
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] active
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NSTG = 7;

  // Configuration registers.
  logic        [RAD_W-1:0]   radius_r;
  logic signed [ROT_W-1:0]   rot_gain_r;
  logic signed [CONV_W-1:0]  conv_gain_r;
  logic signed [SCALE_W-1:0] scale_x_r;
  logic signed [SCALE_W-1:0] scale_y_r;
  logic        [LIM_W-1:0]   limit_x_r;
  logic        [LIM_W-1:0]   limit_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RADIUS_RST;
      rot_gain_r  <= ROT_GAIN_RST;
      conv_gain_r <= CONV_GAIN_RST;
      scale_x_r   <= SCALE_RST;
      scale_y_r   <= SCALE_RST;
      limit_x_r   <= LIMIT_RST;
      limit_y_r   <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RADIUS:    radius_r    <= cfg_wdata[RAD_W-1:0];
        REG_ROT_GAIN:  rot_gain_r  <= cfg_wdata[ROT_W-1:0];
        REG_CONV_GAIN: conv_gain_r <= cfg_wdata[CONV_W-1:0];
        REG_SCALE_X:   scale_x_r   <= cfg_wdata[SCALE_W-1:0];
        REG_SCALE_Y:   scale_y_r   <= cfg_wdata[SCALE_W-1:0];
        REG_LIMIT_X:   limit_x_r   <= cfg_wdata[LIM_W-1:0];
        REG_LIMIT_Y:   limit_y_r   <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and the ready chain running back from the output.
  logic [NSTG:1] vld_r;
  logic [NSTG:1] rdy;
  logic [NSTG:1] vld_nxt;

  always_comb begin
    rdy[NSTG] = !vld_r[NSTG] || out_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = {vld_r[NSTG-1:1], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  assign in_tready  = rdy[1];
  assign out_tvalid = vld_r[NSTG];

  // Stage 1: offsets from the obstacle center.
  logic signed [POS_W-1:0]  veh_x, veh_y;
  logic signed [OBS_W-1:0]  obs_x, obs_y;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r;

  assign veh_x = in_tdata[15:0];
  assign veh_y = in_tdata[31:16];
  assign obs_x = in_tdata[44:32];
  assign obs_y = in_tdata[57:45];
  assign dx_nxt = {veh_x[POS_W-1], veh_x} - {{(DIFF_W-OBS_W){obs_x[OBS_W-1]}}, obs_x};
  assign dy_nxt = {veh_y[POS_W-1], veh_y} - {{(DIFF_W-OBS_W){obs_y[OBS_W-1]}}, obs_y};

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dx1_r <= dx_nxt;
      dy1_r <= dy_nxt;
    end
  end

  // Stage 2: squares, radius squared and the gain products. The gamma
  // products take the offsets at radius width: they only matter when the
  // vehicle is inside the radius, where the offsets fit.
  logic signed [SQ_W-1:0]   dxe, dye, sqx_nxt, sqy_nxt;
  logic signed [ROTP_W-1:0] dx_re, dy_re, rot_e, adx_nxt, ady_nxt;
  logic signed [GD_W-1:0]   dx_ge, dy_ge, conv_e, gdx_nxt, gdy_nxt;
  logic        [R2_W-1:0]   r2_nxt;
  logic        [SQ_W-2:0]   sqx2_r, sqy2_r;
  logic        [R2_W-1:0]   r2_2_r;
  logic signed [ROTP_W-1:0] adx2_r, ady2_r;
  logic signed [GD_W-1:0]   gdx2_r, gdy2_r;

  always_comb begin
    dxe     = {{(SQ_W-DIFF_W){dx1_r[DIFF_W-1]}}, dx1_r};
    dye     = {{(SQ_W-DIFF_W){dy1_r[DIFF_W-1]}}, dy1_r};
    sqx_nxt = dxe * dxe;
    sqy_nxt = dye * dye;
    dx_re   = {{(ROTP_W-DIFF_W){dx1_r[DIFF_W-1]}}, dx1_r};
    dy_re   = {{(ROTP_W-DIFF_W){dy1_r[DIFF_W-1]}}, dy1_r};
    rot_e   = {{(ROTP_W-ROT_W){rot_gain_r[ROT_W-1]}}, rot_gain_r};
    adx_nxt = rot_e * dx_re;
    ady_nxt = rot_e * dy_re;
    dx_ge   = {{(GD_W-RAD_W-1){dx1_r[RAD_W]}}, dx1_r[RAD_W:0]};
    dy_ge   = {{(GD_W-RAD_W-1){dy1_r[RAD_W]}}, dy1_r[RAD_W:0]};
    conv_e  = {{(GD_W-CONV_W){conv_gain_r[CONV_W-1]}}, conv_gain_r};
    gdx_nxt = conv_e * dx_ge;
    gdy_nxt = conv_e * dy_ge;
    r2_nxt  = {{RAD_W{1'b0}}, radius_r} * {{RAD_W{1'b0}}, radius_r};
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sqx2_r <= sqx_nxt[SQ_W-2:0];
      sqy2_r <= sqy_nxt[SQ_W-2:0];
      r2_2_r <= r2_nxt;
      adx2_r <= adx_nxt;
      ady2_r <= ady_nxt;
      gdx2_r <= gdx_nxt;
      gdy2_r <= gdy_nxt;
    end
  end

  // Stage 3: distance test against r^2 and c = r^2 - d^2. Inside the
  // radius c lies in [0, r^2], so radius-squared width holds it.
  logic [DSQ_W-1:0] d2_nxt;
  logic             act_nxt;
  logic [R2_W-1:0]  c_nxt;
  logic             act3_r;
  logic [R2_W-1:0]  c3_r;
  logic signed [ROTP_W-1:0] adx3_r, ady3_r;
  logic signed [GD_W-1:0]   gdx3_r, gdy3_r;

  always_comb begin
    d2_nxt  = sqx2_r + sqy2_r;
    act_nxt = d2_nxt <= {{(DSQ_W-R2_W){1'b0}}, r2_2_r};
    c_nxt   = r2_2_r - d2_nxt[R2_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      act3_r <= act_nxt;
      c3_r   <= c_nxt;
      adx3_r <= adx2_r;
      ady3_r <= ady2_r;
      gdx3_r <= gdx2_r;
      gdy3_r <= gdy2_r;
    end
  end

  // Stage 4: convergence term gamma * d * c.
  logic signed [GC_W-1:0] c_e, gdx_e, gdy_e, gcx_nxt, gcy_nxt;
  logic signed [GC_W-1:0] gcx4_r, gcy4_r;
  logic signed [ROTP_W-1:0] adx4_r, ady4_r;
  logic act4_r;

  always_comb begin
    c_e     = {{(GC_W-R2_W){1'b0}}, c3_r};
    gdx_e   = {{(GC_W-GD_W){gdx3_r[GD_W-1]}}, gdx3_r};
    gdy_e   = {{(GC_W-GD_W){gdy3_r[GD_W-1]}}, gdy3_r};
    gcx_nxt = gdx_e * c_e;
    gcy_nxt = gdy_e * c_e;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      gcx4_r <= gcx_nxt;
      gcy4_r <= gcy_nxt;
      adx4_r <= adx3_r;
      ady4_r <= ady3_r;
      act4_r <= act3_r;
    end
  end

  // Stage 5: field sum in Q(2F), floor to QF, saturate to 32 bits.
  logic signed [SUM_W-1:0] gsx, gsy, rsx, rsy, fx_sum, fy_sum;
  logic signed [SAT_W-1:0] fx_nxt, fy_nxt;
  logic signed [SAT_W-1:0] fx5_r, fy5_r;
  logic act5_r;

  always_comb begin
    gsx    = $signed({gcx4_r[GC_W-1], gcx4_r}) >>> (2 * FRAC_BITS);
    gsy    = $signed({gcy4_r[GC_W-1], gcy4_r}) >>> (2 * FRAC_BITS);
    rsx    = {{(SUM_W-ROTP_W){ady4_r[ROTP_W-1]}}, ady4_r};
    rsy    = {{(SUM_W-ROTP_W){adx4_r[ROTP_W-1]}}, adx4_r};
    fx_sum = (gsx - rsx) >>> FRAC_BITS;
    fy_sum = (gsy + rsy) >>> FRAC_BITS;
    fx_nxt = sat32(fx_sum);
    fy_nxt = sat32(fy_sum);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      fx5_r  <= fx_nxt;
      fy5_r  <= fy_nxt;
      act5_r <= act4_r;
    end
  end

  // Stage 6: apply the per-axis scale.
  logic signed [SPROD_W-1:0] fx_e, fy_e, sx_e, sy_e, px_nxt, py_nxt;
  logic signed [SPROD_W-1:0] px6_r, py6_r;
  logic act6_r;

  always_comb begin
    fx_e   = {{(SPROD_W-SAT_W){fx5_r[SAT_W-1]}}, fx5_r};
    fy_e   = {{(SPROD_W-SAT_W){fy5_r[SAT_W-1]}}, fy5_r};
    sx_e   = {{(SPROD_W-SCALE_W){scale_x_r[SCALE_W-1]}}, scale_x_r};
    sy_e   = {{(SPROD_W-SCALE_W){scale_y_r[SCALE_W-1]}}, scale_y_r};
    px_nxt = fx_e * sx_e;
    py_nxt = fy_e * sy_e;
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      px6_r  <= px_nxt;
      py6_r  <= py_nxt;
      act6_r <= act5_r;
    end
  end

  // Stage 7: floor to QF, clamp to the symmetric limits, gate by the
  // distance test, and hold in the output register.
  logic signed [SPROD_W-1:0] qx, qy, lx, ly, cx, cy;
  logic signed [FORCE_W-1:0] force_x_nxt, force_y_nxt;
  logic signed [FORCE_W-1:0] force_x_r, force_y_r;
  logic act7_r;

  always_comb begin
    qx = px6_r >>> FRAC_BITS;
    qy = py6_r >>> FRAC_BITS;
    lx = {{(SPROD_W-LIM_W){1'b0}}, limit_x_r};
    ly = {{(SPROD_W-LIM_W){1'b0}}, limit_y_r};
    priority if (qx > lx) begin
      cx = lx;
    end else if (qx < -lx) begin
      cx = -lx;
    end else begin
      cx = qx;
    end
    priority if (qy > ly) begin
      cy = ly;
    end else if (qy < -ly) begin
      cy = -ly;
    end else begin
      cy = qy;
    end
    force_x_nxt = act6_r ? cx[FORCE_W-1:0] : '0;
    force_y_nxt = act6_r ? cy[FORCE_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      force_x_r <= force_x_nxt;
      force_y_r <= force_y_nxt;
      act7_r    <= act6_r;
    end
  end

  assign out_tdata = {force_y_r, force_x_r};
  assign out_tuser = act7_r;

endmodule

### verif/testbench.sv
// Testbench for limit_cycle_obstacle_field: directed and random position beats,
// with results checked against a predictor of the field kept in this file.
// Depends on lcof_pkg and the limit_cycle_obstacle_field RTL.
module testbench;
  import lcof_pkg::*;

  localparam int F = FRAC_BITS_DEF;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int PAD_W = IN_DATA_W - 2 * POS_W - 2 * OBS_W;

  typedef struct {
    logic signed [POS_W-1:0] veh_x;
    logic signed [POS_W-1:0] veh_y;
    logic signed [OBS_W-1:0] obs_x;
    logic signed [OBS_W-1:0] obs_y;
  } position_t;

  typedef struct {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic                      active;
  } field_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register copy used by the predictor; it follows every write on the port.
  logic        [RAD_W-1:0]   fld_radius = RADIUS_RST;
  logic signed [ROT_W-1:0]   fld_rot = ROT_GAIN_RST;
  logic signed [CONV_W-1:0]  fld_conv = CONV_GAIN_RST;
  logic signed [SCALE_W-1:0] fld_scale_x = SCALE_RST;
  logic signed [SCALE_W-1:0] fld_scale_y = SCALE_RST;
  logic        [LIM_W-1:0]   fld_limit_x = LIMIT_RST;
  logic        [LIM_W-1:0]   fld_limit_y = LIMIT_RST;

  field_t force_queue[$];
  int     errors = 0;
  logic   steady = 1'b0;

  limit_cycle_obstacle_field u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 21);
  end

  // Saturate the summed component, scale it and clamp it to the limit.
  function automatic logic signed [FORCE_W-1:0] scale_clamp(input longint sum2f,
                                                            input longint scale,
                                                            input longint limit);
    longint v;
    v = sum2f >>> F;
    if (v > SAT_HI) begin
      v = SAT_HI;
    end else if (v < SAT_LO) begin
      v = SAT_LO;
    end
    v = (v * scale) >>> F;
    if (v > limit) begin
      v = limit;
    end else if (v < -limit) begin
      v = -limit;
    end
    return v[FORCE_W-1:0];
  endfunction

  function automatic field_t predict_field(input position_t p);
    longint dx, dy, d2, r2, c, gx, gy, alpha;
    field_t f;
    dx = longint'(p.veh_x) - longint'(p.obs_x);
    dy = longint'(p.veh_y) - longint'(p.obs_y);
    d2 = dx * dx + dy * dy;
    r2 = longint'(fld_radius) * longint'(fld_radius);
    c = r2 - d2;
    alpha = longint'(fld_rot);
    gx = (longint'(fld_conv) * dx * c) >>> (2 * F);
    gy = (longint'(fld_conv) * dy * c) >>> (2 * F);
    f.active = (d2 <= r2);
    f.force_x = '0;
    f.force_y = '0;
    if (f.active) begin
      f.force_x = scale_clamp(gx - alpha * dy, longint'(fld_scale_x), longint'(fld_limit_x));
      f.force_y = scale_clamp(alpha * dx + gy, longint'(fld_scale_y), longint'(fld_limit_y));
    end
    return f;
  endfunction

  task automatic send_position(input position_t p);
    field_t want;
    while (!steady && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    want = predict_field(p);
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, p.obs_y, p.obs_x, p.veh_y, p.veh_x};
    do @(posedge clk); while (!in_tready);
    force_queue.push_back(want);
  endtask

  task automatic send_at(input int vx, input int vy, input int ox, input int oy);
    position_t p;
    p.veh_x = POS_W'(vx);
    p.veh_y = POS_W'(vy);
    p.obs_x = OBS_W'(ox);
    p.obs_y = OBS_W'(oy);
    send_position(p);
  endtask

  // Registers change only with the pipeline empty.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (force_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RADIUS:    fld_radius = data[RAD_W-1:0];
      REG_ROT_GAIN:  fld_rot = data[ROT_W-1:0];
      REG_CONV_GAIN: fld_conv = data[CONV_W-1:0];
      REG_SCALE_X:   fld_scale_x = data[SCALE_W-1:0];
      REG_SCALE_Y:   fld_scale_y = data[SCALE_W-1:0];
      REG_LIMIT_X:   fld_limit_x = data[LIM_W-1:0];
      REG_LIMIT_Y:   fld_limit_y = data[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_field(input logic [15:0] radius, input logic [15:0] rot,
                               input logic [15:0] conv, input logic [15:0] sx,
                               input logic [15:0] sy, input logic [15:0] lx,
                               input logic [15:0] ly);
    write_reg(REG_RADIUS, radius);
    write_reg(REG_ROT_GAIN, rot);
    write_reg(REG_CONV_GAIN, conv);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_LIMIT_X, lx);
    write_reg(REG_LIMIT_Y, ly);
  endtask

  // With the reset radius of zero only a vehicle sitting on the obstacle is active.
  task automatic test_reset_defaults();
    send_at(100, -200, 100, -200);
    send_at(101, -200, 100, -200);
    wait_idle();
  endtask

  task automatic test_directed_extremes();
    // Upper bits of the write data are dropped, so this sets radius 4095.
    program_field(16'hFFFF, 16'd25600, 16'd2560, 16'd256, 16'd256, 16'd25600, 16'd25600);
    send_at(32767, 32767, -4096, -4096);
    send_at(-32768, -32768, 4095, 4095);
    send_at(4095, 0, 0, 0);             // exactly on the cycle
    send_at(4096, 0, 0, 0);             // one step outside
    send_at(-8191, -4096, -4096, -4096);
    send_at(8190, 4095, 4095, 4095);
    send_at(2000, -1500, 0, 0);
    send_at(-300, 700, 10, -20);
    send_at(0, 0, 0, 0);
    wait_idle();
    program_field(16'd4095, 16'h8000, 16'h1000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0);
    send_at(1234, -2345, 0, 0);
    send_at(-4000, 500, -2560, 2560);
    send_at(3000, 2800, 0, 0);
    send_at(-1, 1, 0, 0);
    wait_idle();
    // A write to an index past the register list must change nothing.
    write_reg(REG_SPARE, 16'hFFFF);
    send_at(1000, 1000, 0, 0);
    send_at(-2000, 100, 2560, -2560);
    wait_idle();
  endtask

  task automatic send_random_position();
    position_t p;
    int span;
    p.obs_x = OBS_W'($urandom);
    p.obs_y = OBS_W'($urandom);
    if ($urandom_range(99) < 80) begin
      span = int'(fld_radius) + int'(fld_radius) / 4 + 2;
      p.veh_x = POS_W'(int'(p.obs_x) + int'($urandom_range(2 * span)) - span);
      p.veh_y = POS_W'(int'(p.obs_y) + int'($urandom_range(2 * span)) - span);
    end else begin
      p.veh_x = POS_W'($urandom);
      p.veh_y = POS_W'($urandom);
    end
    send_position(p);
  endtask

  task automatic randomize_field();
    logic [15:0] radius, rot, conv, sx, sy, lx, ly;
    radius = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(2560));
    rot    = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(51200) - 25600);
    conv   = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(5120) - 2560);
    sx     = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(51200) - 25600);
    sy     = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(51200) - 25600);
    lx     = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(25600));
    ly     = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(25600));
    program_field(radius, rot, conv, sx, sy, lx, ly);
  endtask

  task automatic test_random_field(input int phases, input int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      if (ph == 0) begin
        program_field(16'd4095, 16'h7FFF, 16'h0FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      end else if (ph == 1) begin
        program_field(16'd0, 16'h8000, 16'h1000, 16'h8000, 16'h8000, 16'd0, 16'd0);
      end else begin
        randomize_field();
      end
      // One phase runs back to back on both sides.
      steady = (ph == 3);
      for (int i = 0; i < per_phase; i++) begin
        send_random_position();
      end
      wait_idle();
      steady = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    field_t                    want;
    logic signed [FORCE_W-1:0] got_x, got_y;
    if (rst_n && out_tvalid && out_tready) begin
      got_x = out_tdata[FORCE_W-1:0];
      got_y = out_tdata[2*FORCE_W-1:FORCE_W];
      if (force_queue.size() == 0) begin
        errors++;
        $error("result beat with no field expected");
      end else begin
        want = force_queue.pop_front();
        if (got_x !== want.force_x) begin
          errors++;
          $error("force_x: expected %0d, got %0d", want.force_x, got_x);
        end
        if (got_y !== want.force_y) begin
          errors++;
          $error("force_y: expected %0d, got %0d", want.force_y, got_y);
        end
        if (out_tuser !== want.active) begin
          errors++;
          $error("active: expected %0d, got %0d", want.active, out_tuser);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_extremes();
    test_random_field(6, 172);
    repeat (10) @(posedge clk);
    if (errors == 0 && force_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
